// ===== hw/rtl/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm table scheduler package
// Shared types, request codes and constants.
// ----------------------------------------------------------------------------
package ats_pkg;

   localparam int ENTRIES_DEF = 32;

   localparam logic [2:0] REQ_TICK      = 3'd0;
   localparam logic [2:0] REQ_SET       = 3'd1;
   localparam logic [2:0] REQ_CLEAR     = 3'd2;
   localparam logic [2:0] REQ_CLEAR_ALL = 3'd3;
   localparam logic [2:0] REQ_EXPIRE    = 3'd4;

   localparam logic [7:0]  MAX_HOUR   = 8'd23;
   localparam logic [7:0]  MAX_MINUTE = 8'd59;
   localparam logic [7:0]  MAX_DAY    = 8'd31;
   localparam logic [7:0]  MAX_MONTH  = 8'd12;
   localparam logic [15:0] MAX_YEAR   = 16'd3000;
   localparam logic [15:0] MIN_YEAR   = 16'd2000;
   localparam logic [2:0]  SUNDAY_BIT = 3'd6;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  alarm_id;
      logic [7:0]  time_hour;
      logic [7:0]  time_minute;
      logic [7:0]  enable_code;
      logic [7:0]  repeat_mask;
      logic [7:0]  scene_code;
      logic [15:0] date_year;
      logic [7:0]  date_month;
      logic [7:0]  date_day;
      logic [2:0]  weekday;
   } req_type_t_type;

   typedef struct packed {
      logic       accepted;
      logic       fired;
      logic [7:0] fired_scene;
      logic [4:0] fired_hour;
      logic [5:0] fired_minute;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        armed;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  repeat_mask;
      logic [7:0]  scene;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
   } entry_type;

   // Broadcast to every cell: rotate and disarm during a scan step, write and clear_all when a request completes.
   typedef struct packed {
      logic        write;      // load entry at the write slot
      logic        clear_all;
      logic        rotate;     // shift the ring by one
      logic        disarm;     // disarm the entry leaving the head cell
   } cell_ctl_type;

   // Entry is a one-shot whose moment lies before the given clock.
   function automatic logic one_shot_past(input entry_type e, input logic [15:0] cy,
                                          input logic [7:0] cm, input logic [7:0] cd,
                                          input logic [4:0] ch, input logic [5:0] cmi);
      logic        r;
      logic [13:0] at_min, now_min;
      // compare minutes of the day, since a clamped clock minute can exceed 59
      at_min  = 14'(e.hour) * 14'd60 + 14'(e.minute);
      now_min = 14'(ch) * 14'd60 + 14'(cmi);
      r = 1'b0;
      if (e.repeat_mask != 8'd0) r = 1'b0;
      else if (e.year != cy) r = e.year < cy;
      else if (e.month != cm) r = e.month < cm;
      else if (e.day != cd) r = e.day < cd;
      else r = at_min < now_min;
      return r;
   endfunction

endpackage

// ===== hw/rtl/ats_cell.sv =====
// ----------------------------------------------------------------------------
// Alarm table cell
// Holds one entry; passes it to its neighbor when the ring rotates.
// ----------------------------------------------------------------------------
module ats_cell
   import ats_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         is_slot,   // this cell takes the written entry
   input  entry_type    wr_entry,
   input  entry_type    prev_entry,
   output entry_type    entry
);

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.clear_all) begin
         entry_in = '0;
      end else if (ctl.rotate) begin
         entry_in = prev_entry;
      end else if (ctl.write && is_slot) begin
         entry_in = wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// ===== hw/rtl/alarm_table_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// Alarm table scheduler core
// Ring of alarm cells scanned one entry per cycle on tick and expire check.
// ----------------------------------------------------------------------------
// channel | ports                    | handshake
// request | req_payload              | start & !busy
// result  | rsp_payload              | rsp_strobe, one cycle
// Tick and expire check rotate the ring of ENTRIES cells once around in
// ST_SCAN, then end in ST_DONE. Set, clear, clear-all and other codes go to ST_DONE.
// Reset empties the table and zeroes the clock. The receiver cannot stall;
// busy drops in the cycle the result strobe is high.
// ----------------------------------------------------------------------------
module alarm_table_scheduler_core
   import ats_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   input  req_type_t_type req_payload,
   output logic           rsp_strobe,
   output rsp_type        rsp_payload
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type      state_ff;
   req_type_t_type req_ff;
   logic [CW-1:0]  cnt_ff;
   logic           rep_done_ff, stop_ff, fired_ff, acc_ff;
   logic [7:0]     scene_ff;
   logic [15:0]    cy_ff;
   logic [7:0]     cm_ff, cd_ff;
   logic [4:0]     ch_ff;
   logic [5:0]     cmi_ff;
   logic [2:0]     bit_ff;

   entry_type    cells [ENTRIES];
   cell_ctl_type ctl;
   entry_type    wr_entry, head, head_out;
   logic [IW-1:0] slot;

   assign head = cells[ENTRIES-1];

   always_comb begin
      head_out = head;
      if (ctl.disarm) head_out.armed = 1'b0;
   end

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         ats_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .is_slot(slot == IW'(g)), .wr_entry(wr_entry),
            .prev_entry((g == 0) ? head_out : cells[(g == 0) ? 0 : g-1]),
            .entry(cells[g])
         );
      end
   endgenerate

   // set checks, combinational from the registered request
   logic id_ok, set_ok;
   entry_type new_e;
   always_comb begin
      id_ok = (req_ff.alarm_id >= 8'd1) && ({24'd0, req_ff.alarm_id} <= 32'(ENTRIES));
      new_e.valid       = 1'b1;
      new_e.armed       = (req_ff.enable_code == 8'd1);
      new_e.hour        = req_ff.time_hour;
      new_e.minute      = req_ff.time_minute;
      new_e.repeat_mask = req_ff.repeat_mask;
      new_e.scene       = req_ff.scene_code;
      new_e.year        = req_ff.date_year;
      new_e.month       = req_ff.date_month;
      new_e.day         = req_ff.date_day;
      set_ok = id_ok;
      if (req_ff.time_hour > MAX_HOUR || req_ff.time_minute > MAX_MINUTE) set_ok = 1'b0;
      if (req_ff.repeat_mask == 8'd0 &&
          (req_ff.date_day > MAX_DAY || req_ff.date_day == 8'd0 ||
           req_ff.date_month > MAX_MONTH || req_ff.date_month == 8'd0 ||
           req_ff.enable_code > 8'd1 || req_ff.date_year > MAX_YEAR ||
           req_ff.date_year < MIN_YEAR)) set_ok = 1'b0;
      if (set_ok && one_shot_past(new_e, cy_ff, cm_ff, cd_ff, ch_ff, cmi_ff)) set_ok = 1'b0;
      wr_entry = (req_ff.req_type == REQ_SET) ? new_e : '0;
      // entry one sits in the head cell so the scan runs in index order
      slot = IW'(8'(ENTRIES) - req_ff.alarm_id);
   end

   // head cell evaluation during a scan
   logic tm, one_hit, rep_hit, exp_hit;
   always_comb begin
      tm = head.valid && head.armed && head.hour == {3'd0, ch_ff} &&
           head.minute == {2'd0, cmi_ff};
      one_hit = !stop_ff && tm && head.repeat_mask == 8'd0 && head.year == cy_ff &&
                head.month == cm_ff && head.day == cd_ff;
      rep_hit = !stop_ff && tm && head.repeat_mask != 8'd0 && !rep_done_ff &&
                head.repeat_mask[bit_ff];
      exp_hit = head.valid && head.armed &&
                one_shot_past(head, cy_ff, cm_ff, cd_ff, ch_ff, cmi_ff);
      ctl = '0;
      if (state_ff == ST_SCAN) begin
         ctl.rotate = 1'b1;
         ctl.disarm = (req_ff.req_type == REQ_TICK) ? one_hit : exp_hit;
      end else if (state_ff == ST_DONE) begin
         ctl.clear_all = (req_ff.req_type == REQ_CLEAR_ALL);
         ctl.write = (req_ff.req_type == REQ_SET && set_ok) ||
                     (req_ff.req_type == REQ_CLEAR && id_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_strobe <= 1'b0;
         cy_ff <= '0; cm_ff <= '0; cd_ff <= '0; ch_ff <= '0; cmi_ff <= '0;
         cnt_ff <= '0;
         rep_done_ff <= 1'b0; stop_ff <= 1'b0; fired_ff <= 1'b0; acc_ff <= 1'b1;
         scene_ff <= '0; bit_ff <= '0;
      end else begin
         rsp_strobe <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  req_ff <= req_payload;
                  rep_done_ff <= 1'b0; stop_ff <= 1'b0; fired_ff <= 1'b0;
                  scene_ff <= '0; cnt_ff <= '0;
                  if (req_payload.req_type == REQ_TICK) begin
                     cy_ff  <= req_payload.date_year;
                     cm_ff  <= req_payload.date_month;
                     cd_ff  <= req_payload.date_day;
                     ch_ff  <= (req_payload.time_hour > 8'd31) ? 5'd31
                                                              : req_payload.time_hour[4:0];
                     cmi_ff <= (req_payload.time_minute > 8'd63) ? 6'd63
                                                                : req_payload.time_minute[5:0];
                     bit_ff <= (req_payload.weekday == 3'd0) ? SUNDAY_BIT
                                                             : req_payload.weekday - 3'd1;
                  end
                  if (req_payload.req_type == REQ_TICK || req_payload.req_type == REQ_EXPIRE)
                     state_ff <= ST_SCAN;
                  else
                     state_ff <= ST_DONE;
               end
            end
            ST_SCAN: begin
               if (req_ff.req_type == REQ_TICK) begin
                  if (one_hit) begin
                     fired_ff <= 1'b1; scene_ff <= head.scene; stop_ff <= 1'b1;
                  end else if (rep_hit) begin
                     fired_ff <= 1'b1; scene_ff <= head.scene; rep_done_ff <= 1'b1;
                  end
               end
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(ENTRIES - 1)) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_strobe <= 1'b1;
               if (req_ff.req_type == REQ_SET) acc_ff <= set_ok;
               else if (req_ff.req_type == REQ_CLEAR) acc_ff <= id_ok;
               else acc_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   always_comb begin
      rsp_payload.accepted     = acc_ff;
      rsp_payload.fired        = fired_ff;
      rsp_payload.fired_scene  = fired_ff ? scene_ff : 8'd0;
      rsp_payload.fired_hour   = fired_ff ? ch_ff : 5'd0;
      rsp_payload.fired_minute = fired_ff ? cmi_ff : 6'd0;
   end

endmodule

// ===== tb/sv/alarm_table_checker.sv =====
// ----------------------------------------------------------------------------
// Alarm table scheduler checker
// Watches request and result transactions, predicts every result from its
// own copy of the alarm table and clock, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alarm_table_checker
   import ats_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           busy,
   input  req_type_t_type req_payload,
   input  logic           rsp_strobe,
   input  rsp_type        rsp_payload,
   output int             error_count,
   output int             pending_count,
   output int             fire_count
);

   typedef struct {
      logic        valid;
      logic        armed;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  repeat_mask;
      logic [7:0]  scene;
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
   } alarm_slot_t;

   alarm_slot_t slots[ENTRIES];
   logic [15:0] now_year;
   logic [7:0]  now_month, now_day;
   logic [7:0]  now_hour, now_minute;
   rsp_type     expected_rsps[$];

   function automatic logic is_past(alarm_slot_t e);
      int at, now;
      if (e.repeat_mask != 8'd0) return 1'b0;
      if (e.year != now_year) return e.year < now_year;
      if (e.month != now_month) return e.month < now_month;
      if (e.day != now_day) return e.day < now_day;
      at  = e.hour * 60 + e.minute;
      now = now_hour * 60 + now_minute;
      return at < now;
   endfunction

   function automatic rsp_type schedule_step(req_type_t_type r);
      rsp_type     o;
      alarm_slot_t t;
      logic        id_ok, rep_done, ok;
      int          bitpos;
      o = '0;
      o.accepted = 1'b1;
      id_ok = r.alarm_id >= 1 && r.alarm_id <= ENTRIES;
      case (r.req_type)
         REQ_TICK: begin
            rep_done = 1'b0;
            bitpos = (r.weekday == 3'd0) ? 6 : r.weekday - 1;
            now_year = r.date_year;
            now_month = r.date_month;
            now_day = r.date_day;
            now_hour = (r.time_hour > 8'd31) ? 8'd31 : r.time_hour;
            now_minute = (r.time_minute > 8'd63) ? 8'd63 : r.time_minute;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!slots[i].valid || !slots[i].armed) continue;
               if (slots[i].hour != now_hour || slots[i].minute != now_minute) continue;
               if (slots[i].repeat_mask == 8'd0) begin
                  if (slots[i].year == now_year && slots[i].month == now_month &&
                      slots[i].day == now_day) begin
                     o.fired = 1'b1;
                     slots[i].armed = 1'b0;
                     o.fired_scene = slots[i].scene;
                     break;
                  end
               end else if (!rep_done && slots[i].repeat_mask[bitpos]) begin
                  o.fired = 1'b1;
                  o.fired_scene = slots[i].scene;
                  rep_done = 1'b1;
               end
            end
            if (o.fired) begin
               o.fired_hour = now_hour[4:0];
               o.fired_minute = now_minute[5:0];
            end
         end
         REQ_SET: begin
            t.valid = 1'b1;
            t.armed = r.enable_code == 8'd1;
            t.hour = r.time_hour;
            t.minute = r.time_minute;
            t.repeat_mask = r.repeat_mask;
            t.scene = r.scene_code;
            t.year = r.date_year;
            t.month = r.date_month;
            t.day = r.date_day;
            ok = id_ok;
            if (r.time_hour > MAX_HOUR || r.time_minute > MAX_MINUTE) ok = 1'b0;
            if (r.repeat_mask == 8'd0 &&
                (r.date_day > MAX_DAY || r.date_day == 8'd0 ||
                 r.date_month > MAX_MONTH || r.date_month == 8'd0 ||
                 r.enable_code > 8'd1 || r.date_year > MAX_YEAR ||
                 r.date_year < MIN_YEAR)) ok = 1'b0;
            if (ok && is_past(t)) ok = 1'b0;
            if (ok) slots[r.alarm_id - 1] = t;
            o.accepted = ok;
         end
         REQ_CLEAR: begin
            if (id_ok) slots[r.alarm_id - 1] = '{default: '0};
            o.accepted = id_ok;
         end
         REQ_CLEAR_ALL: begin
            foreach (slots[i]) slots[i] = '{default: '0};
         end
         REQ_EXPIRE: begin
            foreach (slots[i])
               if (slots[i].valid && slots[i].armed && is_past(slots[i]))
                  slots[i].armed = 1'b0;
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (slots[i]) slots[i] = '{default: '0};
         now_year = '0;
         now_month = '0;
         now_day = '0;
         now_hour = '0;
         now_minute = '0;
         expected_rsps.delete();
         error_count <= 0;
         fire_count <= 0;
         pending_count <= 0;
      end else begin
         // check the result first: a request in the same cycle is newer
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("result transaction with nothing expected");
               error_count <= error_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.fired) fire_count <= fire_count + 1;
               if (rsp_payload !== want) begin
                  error_count <= error_count + 1;
                  if (rsp_payload.accepted !== want.accepted)
                     $error("accepted: expected %0d, actual %0d",
                            want.accepted, rsp_payload.accepted);
                  if (rsp_payload.fired !== want.fired)
                     $error("fired: expected %0d, actual %0d", want.fired, rsp_payload.fired);
                  if (rsp_payload.fired_scene !== want.fired_scene)
                     $error("fired_scene: expected %0d, actual %0d",
                            want.fired_scene, rsp_payload.fired_scene);
                  if (rsp_payload.fired_hour !== want.fired_hour)
                     $error("fired_hour: expected %0d, actual %0d",
                            want.fired_hour, rsp_payload.fired_hour);
                  if (rsp_payload.fired_minute !== want.fired_minute)
                     $error("fired_minute: expected %0d, actual %0d",
                            want.fired_minute, rsp_payload.fired_minute);
               end
            end
         end
         if (start && !busy) expected_rsps.push_back(schedule_step(req_payload));
         pending_count <= expected_rsps.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Alarm table scheduler testbench
// Directed and random set, clear, clear-all, tick, expire-check and noise
// transactions with random gaps; results are checked by the alarm table checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import ats_pkg::*;

   localparam int NUM_RANDOM = 750;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   req_type_t_type req_payload;
   logic           rsp_strobe;
   rsp_type        rsp_payload;
   int             error_count, pending_count, fire_count;
   int             sent_count;

   // a small pool of clock moments so that alarms set here are hit by ticks
   logic [15:0] pool_year[4]   = '{16'd2000, 16'd2024, 16'd2025, 16'd3000};
   logic [7:0]  pool_month[3]  = '{8'd1, 8'd6, 8'd12};
   logic [7:0]  pool_day[3]    = '{8'd1, 8'd15, 8'd31};
   logic [7:0]  pool_hour[3]   = '{8'd0, 8'd7, 8'd23};
   logic [7:0]  pool_minute[3] = '{8'd0, 8'd30, 8'd59};

   alarm_table_scheduler_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   alarm_table_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .error_count(error_count), .pending_count(pending_count), .fire_count(fire_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("alarm_table_scheduler_core regression: fail");
      $finish;
   end

   // present one transaction and hold it until it is taken
   task automatic send_request(req_type_t_type r);
      int gap;
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clock);
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      sent_count++;
      // step past the edge that drops start; the block is busy then anyway
      @(posedge clock);
   endtask

   function automatic req_type_t_type pool_request(logic [2:0] kind);
      req_type_t_type r;
      r = '0;
      r.req_type = kind;
      r.alarm_id = 8'($urandom_range(1, 32));
      r.time_hour = pool_hour[$urandom_range(0, 2)];
      r.time_minute = pool_minute[$urandom_range(0, 2)];
      r.enable_code = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'd1;
      r.repeat_mask = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
      r.scene_code = 8'($urandom);
      r.date_year = pool_year[$urandom_range(0, 3)];
      r.date_month = pool_month[$urandom_range(0, 2)];
      r.date_day = pool_day[$urandom_range(0, 2)];
      r.weekday = 3'($urandom);
      return r;
   endfunction

   function automatic req_type_t_type noise_request();
      req_type_t_type r;
      r = req_type_t_type'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 1) == 0) r.req_type = 3'($urandom_range(0, 4));
      return r;
   endfunction

   initial begin
      req_type_t_type r;
      int kind;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      sent_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and every request kind
      r = '0; r.req_type = REQ_SET; r.alarm_id = 8'd1; r.time_hour = 8'd23;
      r.time_minute = 8'd59; r.enable_code = 8'd1; r.scene_code = 8'hff;
      r.date_year = 16'd3000; r.date_month = 8'd12; r.date_day = 8'd31;
      send_request(r);
      r.alarm_id = 8'd32; r.date_year = 16'd2000; r.date_month = 8'd1;
      r.date_day = 8'd1; r.time_hour = 8'd0; r.time_minute = 8'd0; r.scene_code = 8'd5;
      send_request(r);
      r.alarm_id = 8'd0; send_request(r);             // bad entry number
      r.alarm_id = 8'd33; send_request(r);
      r.alarm_id = 8'd255; send_request(r);
      r.alarm_id = 8'd2; r.time_hour = 8'd24; send_request(r);   // hour out of range
      r.time_hour = 8'd0; r.time_minute = 8'd60; send_request(r);
      r.time_minute = 8'd0; r.enable_code = 8'd2; send_request(r);
      // repeating entry with odd enable code and bad date: stored disarmed
      r.repeat_mask = 8'hff; r.date_year = 16'hffff; r.date_month = 8'hff;
      r.date_day = 8'hff; send_request(r);
      r.alarm_id = 8'd3; r.enable_code = 8'd1; r.repeat_mask = 8'h40;
      r.time_hour = 8'd7; r.time_minute = 8'd30; r.scene_code = 8'd9;
      send_request(r);
      r.alarm_id = 8'd4; r.repeat_mask = 8'h02; r.scene_code = 8'd10; send_request(r);
      // ticks: Sunday, weekday seven, out-of-range clock, one-shot hit
      r = '0; r.req_type = REQ_TICK; r.time_hour = 8'd7; r.time_minute = 8'd30;
      r.date_year = 16'd2000; r.date_month = 8'd1; r.date_day = 8'd1;
      r.weekday = 3'd0; send_request(r);
      r.weekday = 3'd7; send_request(r);
      r.weekday = 3'd2; send_request(r);
      r.time_hour = 8'd255; r.time_minute = 8'd255; send_request(r);
      r.time_hour = 8'd0; r.time_minute = 8'd0; send_request(r);
      r = '0; r.req_type = REQ_SET; r.alarm_id = 8'd5; r.enable_code = 8'd1;
      r.date_year = 16'd1999; r.date_month = 8'd1; r.date_day = 8'd1;
      send_request(r);                                 // year too small
      r.date_year = 16'd2000; r.date_month = 8'd0; send_request(r);
      r.date_month = 8'd1; r.date_day = 8'd0; send_request(r);
      r = '0; r.req_type = REQ_EXPIRE; send_request(r);
      r.req_type = REQ_CLEAR; r.alarm_id = 8'd3; send_request(r);
      r.alarm_id = 8'd0; send_request(r);
      r.req_type = REQ_CLEAR_ALL; send_request(r);
      r.req_type = 3'd7; send_request(r);
      r.req_type = 3'd5; send_request(r);

      // hold off until the table has answered everything
      while (pending_count != 0) @(posedge clock);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) r = pool_request(REQ_SET);
         else if (kind < 80) r = pool_request(REQ_TICK);
         else if (kind < 85) r = pool_request(REQ_EXPIRE);
         else if (kind < 89) r = pool_request(REQ_CLEAR);
         else if (kind < 90) r = pool_request(REQ_CLEAR_ALL);
         else r = noise_request();
         send_request(r);
         if (n == NUM_RANDOM / 2)
            while (pending_count != 0) @(posedge clock);
      end

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d requests; %0d results reported an alarm firing",
               sent_count, fire_count);
      if (error_count == 0) begin
         $display("alarm_table_scheduler_core regression: pass");
      end else begin
         $display("alarm_table_scheduler_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ats_pkg.sv
hw/rtl/ats_cell.sv
hw/rtl/alarm_table_scheduler_core.sv
tb/sv/alarm_table_checker.sv
tb/sv/testbench.sv
